### src/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

   localparam int DEF_MAX_BLOCKS = 64;

   localparam int ADDR_W   = 32;
   localparam int BYTES_W  = 17;
   localparam int COUNT_W  = 7;
   localparam int SIZE_W   = BYTES_W + 1;
   localparam int ACC_W    = ADDR_W + 1;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;

   // Register reset values
   localparam logic [ADDR_W-1:0]  RST_BASE  = '0;
   localparam logic [BYTES_W-1:0] RST_BYTES = BYTES_W'(4);
   localparam logic [COUNT_W-1:0] RST_COUNT = COUNT_W'(64);

   // Block size rounding: round up to a word, force zero to one word
   localparam logic [SIZE_W-1:0] SIZE_ROUND = SIZE_W'(3);
   localparam logic [SIZE_W-1:0] SIZE_MASK  = ~SIZE_W'(3);
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(4);

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOMEM   = 2'd1,
      STATUS_ILLEGAL = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE  = 2'd0,
      CSR_BYTES = 2'd1,
      CSR_COUNT = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_ALLOC,
      ST_FREE,
      ST_RESP
   } state_type;

   // Sequencer to address unit
   typedef struct packed {
      logic load;
      logic step;
   } unit_ctl_type;

   // Address unit back to sequencer
   typedef struct packed {
      logic hit;
      logic past;
   } unit_sts_type;

endpackage

### src/fbpa_bitmap.sv
`timescale 1ns / 1ps

module fbpa_bitmap #(
   parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
   parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic             wr_bit,
   input  logic [IDX_W-1:0] rd_idx,
   output logic             rd_bit
);

   logic mem [MAX_BLOCKS];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_bit;
      end
   end

   always_ff @(posedge clock) begin
      rd_bit_ff <= mem[rd_idx];
   end

   assign rd_bit = rd_bit_ff;

endmodule

### src/fbpa_addr_unit.sv
`timescale 1ns / 1ps

module fbpa_addr_unit (
   input  logic                            clock,
   input  fbpa_pkg::unit_ctl_type          ctl,
   input  logic [fbpa_pkg::ADDR_W-1:0]     base,
   input  logic [fbpa_pkg::SIZE_W-1:0]     size,
   input  logic [fbpa_pkg::ADDR_W-1:0]     target,
   output logic [fbpa_pkg::ADDR_W-1:0]     acc_addr,
   output fbpa_pkg::unit_sts_type          sts
);

   import fbpa_pkg::*;

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] tgt_ff, tgt_in;

   // One shared adder walks base + i * size; two comparators check it against the target
   always_comb begin
      acc_in = acc_ff;
      tgt_in = tgt_ff;
      if (ctl.load) begin
         acc_in = {1'b0, base};
         tgt_in = {1'b0, target};
      end else if (ctl.step) begin
         acc_in = acc_ff + ACC_W'(size);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      tgt_ff <= tgt_in;
   end

   assign acc_addr = acc_ff[ADDR_W-1:0];
   assign sts.hit  = (acc_ff == tgt_ff);
   assign sts.past = (acc_ff > tgt_ff);

endmodule

### src/fbpa_ctrl.sv
`timescale 1ns / 1ps

module fbpa_ctrl #(
   parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
   parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
   parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fbpa_pkg::kind_type            kind,
   input  logic [CNT_W-1:0]              count,
   input  logic                          out_free,
   output logic                          res_valid,
   output fbpa_pkg::status_type          res_status,
   output logic [fbpa_pkg::ADDR_W-1:0]   res_addr,
   output logic                          mem_we,
   output logic [IDX_W-1:0]              mem_widx,
   output logic                          mem_wbit,
   output logic [IDX_W-1:0]              mem_ridx,
   input  logic                          mem_rbit,
   output fbpa_pkg::unit_ctl_type        unit_ctl,
   input  fbpa_pkg::unit_sts_type        unit_sts,
   input  logic [fbpa_pkg::ADDR_W-1:0]   acc_addr
);

   import fbpa_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [ADDR_W-1:0] chk_addr_ff, chk_addr_in;
   logic              wipe_rsp_ff, wipe_rsp_in;
   status_type        status_ff, status_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   logic fire, scan_lt, found, wipe_last, alloc_issue, free_stop, free_hit;

   assign fire        = req_valid && (state_ff == ST_IDLE);
   assign scan_lt     = (scan_ff < count);
   assign found       = chk_vld_ff && !mem_rbit;
   assign wipe_last   = (scan_ff == CNT_W'(MAX_BLOCKS - 1));
   assign alloc_issue = !found && scan_lt;
   assign free_stop   = !scan_lt || unit_sts.past || unit_sts.hit;
   assign free_hit    = scan_lt && unit_sts.hit;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_WIPE: begin
            if (wipe_last) begin
               state_in = wipe_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (fire) begin
               unique case (kind)
                  KIND_ALLOC: state_in = ST_ALLOC;
                  KIND_FREE:  state_in = ST_FREE;
                  KIND_CLEAR: state_in = ST_WIPE;
                  KIND_NOP:   state_in = ST_RESP;
               endcase
            end
         end
         ST_ALLOC: begin
            if (!alloc_issue) begin
               state_in = ST_RESP;
            end
         end
         ST_FREE: begin
            if (free_stop) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      res_valid     = (state_ff == ST_RESP);
      mem_we        = 1'b0;
      mem_widx      = scan_ff[IDX_W-1:0];
      mem_wbit      = 1'b0;
      mem_ridx      = scan_ff[IDX_W-1:0];
      unit_ctl.load = fire;
      unit_ctl.step = 1'b0;
      unique case (state_ff)
         ST_WIPE: begin
            mem_we = 1'b1;
         end
         ST_ALLOC: begin
            if (found) begin
               mem_we   = 1'b1;
               mem_widx = chk_idx_ff;
               mem_wbit = 1'b1;
            end
            unit_ctl.step = alloc_issue;
         end
         ST_FREE: begin
            mem_we        = free_hit && !unit_sts.past;
            unit_ctl.step = !free_stop;
         end
         ST_IDLE, ST_RESP: begin
         end
      endcase
   end

   // Working registers
   always_comb begin
      scan_in     = scan_ff;
      chk_vld_in  = chk_vld_ff;
      chk_idx_in  = chk_idx_ff;
      chk_addr_in = chk_addr_ff;
      wipe_rsp_in = wipe_rsp_ff;
      status_in   = status_ff;
      addr_in     = addr_ff;
      unique case (state_ff)
         ST_WIPE: begin
            scan_in   = scan_ff + CNT_W'(1);
            status_in = STATUS_OK;
            addr_in   = '0;
         end
         ST_IDLE: begin
            if (fire) begin
               scan_in     = '0;
               chk_vld_in  = 1'b0;
               wipe_rsp_in = (kind == KIND_CLEAR);
               status_in   = STATUS_OK;
               addr_in     = '0;
            end
         end
         ST_ALLOC: begin
            if (found) begin
               status_in = STATUS_OK;
               addr_in   = chk_addr_ff;
            end else if (scan_lt) begin
               scan_in     = scan_ff + CNT_W'(1);
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_ff[IDX_W-1:0];
               chk_addr_in = acc_addr;
            end else begin
               status_in = STATUS_NOMEM;
               addr_in   = '0;
            end
         end
         ST_FREE: begin
            priority if (!scan_lt || unit_sts.past) begin
               status_in = STATUS_ILLEGAL;
            end else if (unit_sts.hit) begin
               status_in = STATUS_OK;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
            addr_in = '0;
         end
         ST_RESP: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_WIPE;
         scan_ff     <= '0;
         chk_vld_ff  <= 1'b0;
         wipe_rsp_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_ff     <= scan_in;
         chk_vld_ff  <= chk_vld_in;
         wipe_rsp_ff <= wipe_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      chk_addr_ff <= chk_addr_in;
      status_ff   <= status_in;
      addr_ff     <= addr_in;
   end

   assign res_status = status_ff;
   assign res_addr   = addr_ff;

endmodule

### src/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps

// Fixed-size block pool allocator with a used bitmap.
// Request channel (req_): tuser carries the kind (allocate, free, clear, no-op),
// tdata the address to free. One transfer in, one transfer out on rsp_:
// tuser carries the status, tdata the allocated address (zero otherwise).
// Configuration channel (csr_): index 0 base address, 1 block size in bytes,
// 2 block count; always ready, write only while no request is in flight.
// Allocate and free walk the pool one block per cycle with a single shared adder
// and a shared comparator pair; allocate stops at the first free block or at the
// end of the pool, free at the matching address, at the end of the pool or once
// the walk passes the address. A clear writes the bitmap one entry per cycle; a
// no-op goes straight to the response. req_tready rises as the result moves to
// the output register.
// Reset: a wipe empties the bitmap before req_tready rises; registers return to
// base 0, size 4, count 64.
// Stall: a result waits in the output register. The sequencer holds a finished
// result, with req_tready low, until that register frees; once the result has
// moved on, the next request may enter while it waits.
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tuser = {kind[1:0]}, tdata = {free_address[31:0]}
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fbpa_pkg::KIND_W-1:0]       req_tuser,
   input  logic [fbpa_pkg::ADDR_W-1:0]       req_tdata,
   // response: tuser = {status[1:0]}, tdata = {block_address[31:0]}
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fbpa_pkg::STATUS_W-1:0]     rsp_tuser,
   output logic [fbpa_pkg::ADDR_W-1:0]       rsp_tdata,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]       csr_data
);

   import fbpa_pkg::*;

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;

   logic [SIZE_W-1:0] size_round;
   logic [SIZE_W-1:0] eff_size;
   logic [CNT_W-1:0]  eff_count;
   logic              out_free;

   logic              res_valid;
   status_type        res_status;
   logic [ADDR_W-1:0] res_addr;

   logic             mem_we, mem_wbit, mem_rbit;
   logic [IDX_W-1:0] mem_widx, mem_ridx;

   unit_ctl_type      unit_ctl;
   unit_sts_type      unit_sts;
   logic [ADDR_W-1:0] acc_addr;

   // Register file: take every transfer, drop unknown indexes
   assign csr_ready = 1'b1;

   always_comb begin
      base_in  = base_ff;
      bytes_in = bytes_ff;
      count_in = count_ff;
      if (csr_valid) begin
         if (csr_index == CSR_BASE) begin
            base_in = csr_data;
         end
         if (csr_index == CSR_BYTES) begin
            bytes_in = csr_data[BYTES_W-1:0];
         end
         if (csr_index == CSR_COUNT) begin
            count_in = csr_data[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= RST_BASE;
         bytes_ff <= RST_BYTES;
         count_ff <= RST_COUNT;
      end else begin
         base_ff  <= base_in;
         bytes_ff <= bytes_in;
         count_ff <= count_in;
      end
   end

   // Round the block size up to a whole word; a zero size counts as one word
   assign size_round = (SIZE_W'(bytes_ff) + SIZE_ROUND) & SIZE_MASK;
   assign eff_size   = (size_round == '0) ? SIZE_MIN : size_round;

   // Saturate the block count at the bitmap depth
   assign eff_count = (32'(count_ff) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(count_ff);

   // Output register: load when empty or when the current transfer leaves
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (out_free) begin
         rsp_valid_in  = res_valid;
         rsp_status_in = res_status;
         rsp_addr_in   = res_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_addr_ff;

   fbpa_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .kind       (kind_type'(req_tuser)),
      .count      (eff_count),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res_status (res_status),
      .res_addr   (res_addr),
      .mem_we     (mem_we),
      .mem_widx   (mem_widx),
      .mem_wbit   (mem_wbit),
      .mem_ridx   (mem_ridx),
      .mem_rbit   (mem_rbit),
      .unit_ctl   (unit_ctl),
      .unit_sts   (unit_sts),
      .acc_addr   (acc_addr)
   );

   fbpa_addr_unit u_addr_unit (
      .clock    (clock),
      .ctl      (unit_ctl),
      .base     (base_ff),
      .size     (eff_size),
      .target   (req_tdata),
      .acc_addr (acc_addr),
      .sts      (unit_sts)
   );

   fbpa_bitmap #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .IDX_W      (IDX_W)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_idx (mem_widx),
      .wr_bit (mem_wbit),
      .rd_idx (mem_ridx),
      .rd_bit (mem_rbit)
   );

endmodule
